// ----- design/ssld_pkg.sv -----
// ssld_pkg: shared types, widths and codes for the sliding sad lap detector
// no dependencies; imported by ssld_ctrl, ssld_datapath and the top level
package ssld_pkg;

	localparam int DEF_WINDOW      = 128;
	localparam int DEF_SLIDE       = 32;
	localparam int DEF_SAMPLE_BITS = 12;

	localparam int SAMPLE_W    = 12;
	localparam int DUMP_W      = 16;
	localparam int SAD_W       = 19;
	localparam int CFG_ADDR_W  = 1;
	localparam int CFG_DATA_W  = 19;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 24;

	localparam logic [CFG_ADDR_W-1:0] REG_DUMP_COUNT    = 1'b0;
	localparam logic [CFG_ADDR_W-1:0] REG_SAD_THRESHOLD = 1'b1;

	localparam logic [DUMP_W-1:0] DUMP_RESET      = 16'd0;
	localparam logic [SAD_W-1:0]  THRESHOLD_RESET = 19'd4096;
	localparam logic [SAD_W-1:0]  SAD_MAX         = 19'h7FFFF;

	typedef enum logic [1:0] {
		PH_REF,
		PH_FILL,
		PH_SLIDE
	} phase_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SAD,
		ST_EMIT
	} ctrl_state_t;

	typedef struct packed {
		logic load;
		logic sad_start;
		logic commit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic trig;
		logic sad_done;
		logic out_free;
	} dp_stat_t;

endpackage

// ----- design/ssld_ram.sv -----
// ssld_ram: generic single write, single read ram with registered read data
// no dependencies
module ssld_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- design/ssld_ctrl.sv -----
// ssld_ctrl: control state machine, sequences accept, sad walk and result commit
// depends on ssld_pkg
module ssld_ctrl
	import ssld_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	input  dp_stat_t  stat,
	output ctrl_cmd_t cmd
);

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					if (stat.trig) begin
						cmd.sad_start = 1'b1;
						state_d       = ST_SAD;
					end else begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_SAD: begin
				if (stat.sad_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- design/ssld_datapath.sv -----
// ssld_datapath: config registers, fill counters, reference and window rams,
// sad accumulator and output register; depends on ssld_pkg and ssld_ram
module ssld_datapath
	import ssld_pkg::*;
#(
	parameter int WINDOW      = DEF_WINDOW,
	parameter int SLIDE       = DEF_SLIDE,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                   in_action,
	input  logic [SAMPLE_W-1:0]    in_sample,
	input  ctrl_cmd_t              cmd,
	output dp_stat_t               stat,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	localparam int AW     = $clog2(WINDOW);
	localparam int MAXN   = (WINDOW > SLIDE) ? WINDOW : SLIDE;
	localparam int FILL_W = $clog2(MAXN + 1);
	localparam int RAW_W  = SAMPLE_BITS + $clog2(WINDOW) + 1;
	localparam int ACC_W  = (RAW_W > SAD_W) ? RAW_W : SAD_W + 1;

	logic [DUMP_W-1:0]      dump_q;
	logic [SAD_W-1:0]       thresh_q;
	phase_t                 phase_q, phase_d;
	logic [FILL_W-1:0]      fill_q, fill_d;
	logic [DUMP_W-1:0]      discard_q, discard_d;
	logic [AW-1:0]          wptr_q, wptr_d;
	logic                   act_q;
	logic [SAMPLE_BITS-1:0] smp_q;
	logic                   cmp_q;

	logic                   rd_busy_q;
	logic [AW-1:0]          rd_idx_q;
	logic [AW-1:0]          rd_win_q;
	logic                   rd_vld_s1;
	logic [ACC_W-1:0]       acc_q;

	logic                   out_vld_q;
	logic [OUT_TDATA_W-1:0] out_data_q;

	logic                   ref_we, win_we;
	logic [SAMPLE_BITS-1:0] ref_rdata, win_rdata;
	logic [SAMPLE_BITS-1:0] diff;
	logic                   discarding;
	logic                   batch_full;
	logic [SAD_W-1:0]       score;
	logic                   lap;
	logic [AW-1:0]          wptr_inc;

	ssld_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(WINDOW)
	) u_ref_ram (
		.clk  (clk),
		.we   (ref_we),
		.waddr(fill_q[AW-1:0]),
		.wdata(smp_q),
		.raddr(rd_idx_q),
		.rdata(ref_rdata)
	);

	ssld_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(WINDOW)
	) u_win_ram (
		.clk  (clk),
		.we   (win_we),
		.waddr(wptr_q),
		.wdata(smp_q),
		.raddr(rd_win_q),
		.rdata(win_rdata)
	);

	assign discarding = discard_q < dump_q;
	assign batch_full = (phase_q == PH_FILL) ? (fill_q == FILL_W'(WINDOW)) :
		((phase_q != PH_REF) && (fill_q == FILL_W'(SLIDE)));
	assign wptr_inc = (wptr_q == AW'(WINDOW - 1)) ? '0 : wptr_q + AW'(1);

	assign stat.trig     = !in_action && !discarding && batch_full;
	assign stat.sad_done = !rd_busy_q && !rd_vld_s1;
	assign stat.out_free = !out_vld_q || m_tready;

	assign diff  = (win_rdata >= ref_rdata) ? win_rdata - ref_rdata : ref_rdata - win_rdata;
	assign score = (acc_q > ACC_W'(SAD_MAX)) ? SAD_MAX : acc_q[SAD_W-1:0];
	assign lap   = score < thresh_q;

	// state update for the committed word
	always_comb begin
		phase_d   = phase_q;
		fill_d    = fill_q;
		discard_d = discard_q;
		wptr_d    = wptr_q;
		ref_we    = 1'b0;
		win_we    = 1'b0;
		if (cmd.commit) begin
			if (act_q) begin
				phase_d   = PH_REF;
				fill_d    = '0;
				discard_d = '0;
				wptr_d    = '0;
			end else if (discarding) begin
				discard_d = discard_q + DUMP_W'(1);
			end else begin
				unique case (phase_q)
					PH_REF: begin
						if (fill_q < FILL_W'(WINDOW)) begin
							ref_we = 1'b1;
							fill_d = fill_q + FILL_W'(1);
						end else begin
							phase_d = PH_FILL;
							win_we  = 1'b1;
							wptr_d  = wptr_inc;
							fill_d  = FILL_W'(1);
						end
					end
					PH_FILL: begin
						win_we = 1'b1;
						wptr_d = wptr_inc;
						if (fill_q < FILL_W'(WINDOW)) begin
							fill_d = fill_q + FILL_W'(1);
						end else begin
							phase_d = PH_SLIDE;
							fill_d  = FILL_W'(1);
						end
					end
					default: begin
						win_we = 1'b1;
						wptr_d = wptr_inc;
						if (fill_q < FILL_W'(SLIDE)) begin
							fill_d = fill_q + FILL_W'(1);
						end else begin
							fill_d = FILL_W'(1);
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dump_q    <= DUMP_RESET;
			thresh_q  <= THRESHOLD_RESET;
			phase_q   <= PH_REF;
			fill_q    <= '0;
			discard_q <= '0;
			wptr_q    <= '0;
			rd_busy_q <= 1'b0;
			rd_vld_s1 <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					REG_DUMP_COUNT:    dump_q   <= cfg_wdata[DUMP_W-1:0];
					REG_SAD_THRESHOLD: thresh_q <= cfg_wdata[SAD_W-1:0];
					default: ;
				endcase
			end
			phase_q   <= phase_d;
			fill_q    <= fill_d;
			discard_q <= discard_d;
			wptr_q    <= wptr_d;
			if (cmd.sad_start) begin
				rd_busy_q <= 1'b1;
			end else if (rd_busy_q && rd_idx_q == AW'(WINDOW - 1)) begin
				rd_busy_q <= 1'b0;
			end
			rd_vld_s1 <= rd_busy_q;
			if (cmd.commit) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// item latch, sad walk pointers, accumulator, result word
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= in_action;
			smp_q <= SAMPLE_BITS'(in_sample);
			cmp_q <= stat.trig;
		end
		if (cmd.sad_start) begin
			rd_idx_q <= '0;
			rd_win_q <= wptr_q;
			acc_q    <= '0;
		end else begin
			if (rd_busy_q) begin
				rd_idx_q <= rd_idx_q + AW'(1);
				rd_win_q <= (rd_win_q == AW'(WINDOW - 1)) ? '0 : rd_win_q + AW'(1);
			end
			if (rd_vld_s1) begin
				acc_q <= acc_q + ACC_W'(diff);
			end
		end
		if (cmd.commit) begin
			if (cmp_q && !act_q) begin
				out_data_q <= {(OUT_TDATA_W - SAD_W - 2)'(0), score, 1'b1, lap};
			end else begin
				out_data_q <= '0;
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;

endmodule

// ----- design/sliding_sad_lap_detector.sv -----
// sliding_sad_lap_detector: top level, joins control state machine and datapath
// depends on ssld_pkg, ssld_ctrl, ssld_datapath
//
//   group   dir  handshake           payload
//   s_      in   s_tvalid/s_tready   s_tdata: sample[11:0]; s_tuser: action
//   m_      out  m_tvalid/m_tready   m_tdata: lap_detected, compared, sad_score
//   cfg_    in   cfg_we              cfg_addr, cfg_wdata
//
// a plain word is accepted in ST_IDLE and committed from ST_EMIT; a word that closes a batch
// first runs the sad walk, reading one reference and one window ram entry per cycle
// a one-word output register lets the next word be accepted while a result waits
// on m_tready; a commit stalls only when that register is still full
// reset is asynchronous, active low; rams are not cleared and are never read unwritten
module sliding_sad_lap_detector
	import ssld_pkg::*;
#(
	parameter int WINDOW      = DEF_WINDOW,
	parameter int SLIDE       = DEF_SLIDE,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // sample [11:0], zero [15:12]
	input  logic                   s_tuser,   // action
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // lap_detected, compared, sad_score [20:2]
	input  logic                   cfg_we,
	input  logic [CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	ssld_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	ssld_datapath #(
		.WINDOW     (WINDOW),
		.SLIDE      (SLIDE),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.in_action(s_tuser),
		.in_sample(s_tdata[SAMPLE_W-1:0]),
		.cmd      (cmd),
		.stat     (stat),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	a_lap_needs_compare: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[1])
		else $error("lap flagged without a comparison");

	a_score_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[1] |-> m_tdata[SAD_W+1:2] == '0)
		else $error("nonzero score without a comparison");

	a_no_walk_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> stat.sad_done)
		else $error("input ready while sad walk runs");

	a_commit_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> stat.out_free)
		else $error("commit into a full output register");

endmodule
